/* hw/rtl/hse_pkg.sv */
package hse_pkg;

	// Default number of entries in the heap store.
	localparam int CAPACITY = 64;

	// Width of one stored value.
	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_out;
		logic                     overflow;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_READ,
		ST_CMP,
		ST_NEXT,
		ST_EMIT
	} state_t;

endpackage

/* hw/rtl/hse_ram.sv */
module hse_ram #(
	parameter int DEPTH = hse_pkg::CAPACITY,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [hse_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr_a,
	input  logic [AW-1:0]             raddr_b,
	output logic [hse_pkg::DATA_W-1:0] rdata_a,
	output logic [hse_pkg::DATA_W-1:0] rdata_b
);

	// One write port and two registered read ports. A read at the address
	// written in the same cycle returns the old contents.
	logic [hse_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* hw/rtl/heap_sort_engine_top.sv */
// Channel   Ports                 Handshake                      Word
// -------   -------------------   ----------------------------   -----------------
// input     start, busy, item     taken when start && !busy      value, is_last
// output    strobe, result        valid for one cycle on strobe  sorted_value,
//                                                                last_out, overflow
//
// Loading accepts one word per cycle. The word marked last starts the sort.
// A sift passes FETCH and LOAD, then READ and CMP for each level the value descends, and ends in NEXT.
// A set of n values runs n/2 build sifts and n - 1 extraction sifts.
// The sorted values then come out one per cycle.
// Reset clears the control state only; the heap memory is never cleared.
// The receiver cannot stall. busy falls in the cycle that shows the final result.
module heap_sort_engine_top #(
	parameter int CAPACITY = hse_pkg::CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  hse_pkg::in_word_t  item,
	output logic               strobe,
	output hse_pkg::out_word_t result
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = IW + 2;
	localparam int DW = hse_pkg::DATA_W;

	hse_pkg::state_t state_q, state_d;

	logic [CW-1:0]        count_q, count_d;
	logic                 ovf_q, ovf_d;
	logic                 extract_q, extract_d;
	logic [IW-1:0]        top_q, top_d;
	logic [IW-1:0]        idx_q, idx_d;
	logic [IW-1:0]        node_q, node_d;
	logic [IW-1:0]        last_q, last_d;
	logic [IW-1:0]        child_q, child_d;
	logic                 rok_q, rok_d;
	logic [IW-1:0]        k_q, k_d;
	logic signed [DW-1:0] v_q, v_d;

	logic strobe_s1, strobe_d;
	logic lastout_s1, lastout_d;
	logic ovfout_s1, ovfout_d;

	logic          we;
	logic [IW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic [IW-1:0] raddr_a, raddr_b;
	logic [DW-1:0] rdata_a, rdata_b;

	logic [CW-1:0]        n_new;
	logic [XW-1:0]        child_x;
	logic                 rsel;
	logic signed [DW-1:0] cval;

	hse_ram #(
		.DEPTH(CAPACITY),
		.AW   (IW)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign busy   = (state_q != hse_pkg::ST_IDLE);
	assign strobe = strobe_s1;

	always_comb begin
		result.sorted_value = $signed(rdata_a);
		result.last_out     = lastout_s1;
		result.overflow     = ovfout_s1;
	end

	// Count after the current word, should it be stored.
	assign n_new   = (count_q < CW'(CAPACITY)) ? count_q + CW'(1) : count_q;
	// Left child of the current node, wide enough never to wrap.
	assign child_x = XW'({node_q, 1'b1});
	// Pick the larger child; the right one only if it lies in range.
	assign rsel    = rok_q && ($signed(rdata_b) > $signed(rdata_a));
	assign cval    = rsel ? $signed(rdata_b) : $signed(rdata_a);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ovf_d     = ovf_q;
		extract_d = extract_q;
		top_d     = top_q;
		idx_d     = idx_q;
		node_d    = node_q;
		last_d    = last_q;
		child_d   = child_q;
		rok_d     = rok_q;
		k_d       = k_q;
		v_d       = v_q;
		strobe_d  = 1'b0;
		lastout_d = 1'b0;
		ovfout_d  = ovfout_s1;
		we        = 1'b0;
		waddr     = node_q;
		wdata     = v_q;
		raddr_a   = top_q;
		raddr_b   = idx_q;

		case (state_q)
			hse_pkg::ST_IDLE: begin
				if (start) begin
					if (count_q < CW'(CAPACITY)) begin
						we      = 1'b1;
						waddr   = count_q[IW-1:0];
						wdata   = item.value;
						count_d = n_new;
					end else begin
						ovf_d = 1'b1;
					end
					if (item.is_last) begin
						if (n_new >= CW'(2)) begin
							extract_d = 1'b0;
							top_d     = IW'((n_new >> 1) - CW'(1));
							last_d    = IW'(n_new - CW'(1));
							state_d   = hse_pkg::ST_FETCH;
						end else begin
							k_d     = '0;
							state_d = hse_pkg::ST_EMIT;
						end
					end
				end
			end

			hse_pkg::ST_FETCH: begin
				// Build reads the sift start; extraction reads root and tail.
				raddr_a = extract_q ? '0 : top_q;
				raddr_b = idx_q;
				state_d = hse_pkg::ST_LOAD;
			end

			hse_pkg::ST_LOAD: begin
				if (extract_q) begin
					// The old root goes to the tail; the tail value sifts from the root.
					we     = 1'b1;
					waddr  = idx_q;
					wdata  = rdata_a;
					v_d    = $signed(rdata_b);
					node_d = '0;
					last_d = idx_q - IW'(1);
				end else begin
					v_d    = $signed(rdata_a);
					node_d = top_q;
				end
				state_d = hse_pkg::ST_READ;
			end

			hse_pkg::ST_READ: begin
				if (child_x > XW'(last_q)) begin
					we      = 1'b1;
					waddr   = node_q;
					wdata   = v_q;
					state_d = hse_pkg::ST_NEXT;
				end else begin
					rok_d   = (child_x + XW'(1)) <= XW'(last_q);
					raddr_a = child_x[IW-1:0];
					raddr_b = rok_d ? IW'(child_x + XW'(1)) : child_x[IW-1:0];
					child_d = child_x[IW-1:0];
					state_d = hse_pkg::ST_CMP;
				end
			end

			hse_pkg::ST_CMP: begin
				we    = 1'b1;
				waddr = node_q;
				if (cval > v_q) begin
					// The sifting value is written only where it comes to rest.
					wdata   = cval;
					node_d  = rsel ? child_q + IW'(1) : child_q;
					state_d = hse_pkg::ST_READ;
				end else begin
					wdata   = v_q;
					state_d = hse_pkg::ST_NEXT;
				end
			end

			hse_pkg::ST_NEXT: begin
				if (!extract_q) begin
					if (top_q == '0) begin
						extract_d = 1'b1;
						idx_d     = IW'(count_q - CW'(1));
					end else begin
						top_d = top_q - IW'(1);
					end
					state_d = hse_pkg::ST_FETCH;
				end else if (idx_q == IW'(1)) begin
					k_d     = '0;
					state_d = hse_pkg::ST_EMIT;
				end else begin
					idx_d   = idx_q - IW'(1);
					state_d = hse_pkg::ST_FETCH;
				end
			end

			hse_pkg::ST_EMIT: begin
				raddr_a  = k_q;
				strobe_d = 1'b1;
				ovfout_d = ovf_q;
				if (CW'(k_q) == count_q - CW'(1)) begin
					lastout_d = 1'b1;
					count_d   = '0;
					ovf_d     = 1'b0;
					state_d   = hse_pkg::ST_IDLE;
				end else begin
					k_d = k_q + IW'(1);
				end
			end

			default: begin
				state_d = hse_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hse_pkg::ST_IDLE;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			extract_q  <= 1'b0;
			strobe_s1  <= 1'b0;
			lastout_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			ovf_q      <= ovf_d;
			extract_q  <= extract_d;
			strobe_s1  <= strobe_d;
			lastout_s1 <= lastout_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q     <= top_d;
		idx_q     <= idx_d;
		node_q    <= node_d;
		last_q    <= last_d;
		child_q   <= child_d;
		rok_q     <= rok_d;
		k_q       <= k_d;
		v_q       <= v_d;
		ovfout_s1 <= ovfout_d;
	end

endmodule

/* hw/rtl/hse_checker.sv */
module hse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input hse_pkg::in_word_t  item,
	input logic               strobe,
	input hse_pkg::out_word_t result
);

	// A closing word always starts a sort.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.is_last |=> busy)
		else $error("closing word did not start a sort");

	// A word that does not close a set gives no result.
	a_quiet_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !item.is_last |=> !strobe)
		else $error("result after a word that did not close the set");

	// Results of one set come back to back.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_out |=> strobe)
		else $error("gap inside a result run");

	// The final result ends the run.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_out |=> !strobe)
		else $error("result after the final one");

	// Only the final result may appear while the block is idle.
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_out |-> busy)
		else $error("result outside a sort");

endmodule

bind heap_sort_engine_top hse_checker u_hse_checker (.*);
